// File: rtl/jhp_pkg.sv
// ----------------------------------------------------------------------------
// jhp_pkg
// Types and constants shared by the JPEG header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package jhp_pkg;

  typedef enum logic [3:0] {
    PH_SOI_FF   = 4'd0,
    PH_SOI_CODE = 4'd1,
    PH_MARK_FF  = 4'd2,
    PH_MARK     = 4'd3,
    PH_LEN_HI   = 4'd4,
    PH_LEN_LO   = 4'd5,
    PH_DATA     = 4'd6,
    PH_SCAN     = 4'd7,
    PH_FAIL     = 4'd8
  } phase_t;

  localparam logic [7:0] MK_SOF0 = 8'hC0;
  localparam logic [7:0] MK_SOS  = 8'hDA;
  localparam logic [7:0] MK_DQT  = 8'hDB;
  localparam logic [7:0] MK_DRI  = 8'hDD;
  localparam logic [7:0] MK_SOI  = 8'hD8;
  localparam logic [7:0] MK_EOI  = 8'hD9;
  localparam logic [7:0] BYTE_FF = 8'hFF;

  localparam logic [24:0] POS_MAX = 25'h1FF_FFFF;
  localparam logic [23:0] LIM24   = 24'hFF_FFFF;
  localparam logic [15:0] DIM_MAX = 16'd2040;

  localparam logic RK_TABLE   = 1'b0;
  localparam logic RK_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  table_byte;
    logic [8:0]  table_index;
    logic        frame_ok;
    logic [6:0]  frame_type;
    logic [7:0]  width_units;
    logic [7:0]  height_units;
    logic [15:0] dri_interval;
    logic [9:0]  table_length;
    logic [7:0]  table_precision;
    logic [23:0] scan_begin;
    logic [23:0] scan_length;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/jpeg_header_parser_unit.sv
// ----------------------------------------------------------------------------
// jpeg_header_parser_unit
// Byte-serial marker segment parser for one baseline JPEG frame.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one frame byte per request; in_data.last_byte marks the final byte.
//   out_* : table bytes of DQT segments (kind 0) and one end-of-frame summary
//           (kind 1) on the last byte. Bytes that give no result produce none.
//   Throughput: one byte per cycle while the output register is not held by
//   out_stall. All parsing for a byte is done in the cycle it is accepted;
//   its result, if any, sits in the output register from the next cycle.
//   Stall: the output register holds while out_stall is high; a byte is still
//   taken when the register empties in the same cycle (in_stall follows
//   out_valid_r && out_stall only).
//   Reset: all parse state returns to "expect start of image", the output
//   register empties. After each summary the state clears for the next frame.
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_header_parser_unit #(
  parameter int MAX_TABLE_BYTES = 512
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire jhp_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output jhp_pkg::out_item_t     out_data
);

  localparam int TW = $clog2(MAX_TABLE_BYTES + 1);

  jhp_pkg::phase_t phase_r, phase_nxt;
  logic [24:0] pos_r, pos_nxt;
  logic [15:0] seg_rem_r, seg_rem_nxt;
  logic [15:0] seg_pos_r, seg_pos_nxt;
  logic [7:0]  marker_r, marker_nxt;
  logic [7:0]  tleft_r, tleft_nxt;
  logic [TW-1:0] tcoll_r, tcoll_nxt;
  logic [7:0]  prec_r, prec_nxt;
  logic [15:0] height_r, height_nxt;
  logic [15:0] width_r, width_nxt;
  logic [7:0]  comps_r, comps_nxt;
  logic        samp_r, samp_nxt;
  logic [15:0] dri_r, dri_nxt;
  logic        seen_sof_r, seen_sof_nxt;
  logic        seen_sos_r, seen_sos_nxt;
  logic        err_r, err_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [23:0] sstart_r, sstart_nxt;

  logic               out_valid_r, out_valid_nxt;
  jhp_pkg::out_item_t out_data_r, out_data_nxt;

  logic       accept;
  logic [7:0] b;
  logic       last;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign b         = in_data.data_byte;
  assign last      = in_data.last_byte;

  // Segment end checks shared by length and data phases
  logic [15:0] seg_full, seg_after_len, seg_dec, seg_len_end;
  logic        end_fail, end_scan, end_sof;
  logic [25:0] next_pos;
  logic [9:0]  comp_need;
  logic        standalone;
  logic [7:0]  tsize;
  logic [TW:0] tsum;
  logic        emit;
  logic [15:0] end_len;

  always_comb begin
    seg_full      = {seg_rem_r[15:8], b};
    seg_after_len = seg_full - 16'd2;
    seg_dec       = seg_rem_r - 16'd1;
    // one bit wider so a saturated position still gives the true offset
    next_pos      = {1'b0, pos_r} + 26'd1;
    standalone    = (b == jhp_pkg::MK_EOI) || (b == 8'h00) || (b == 8'h01) ||
                    (b[7:3] == 5'b11010);
    tsize         = (b[7:4] == 4'd0) ? 8'd64 : 8'd128;
    tsum          = {1'b0, tcoll_r} + (TW+1)'(tsize);
    // length at segment end: zero in length phase, seg_pos+1 in data phase
    end_len       = (phase_r == jhp_pkg::PH_LEN_LO) ? 16'd0 : seg_pos_r + 16'd1;
    seg_len_end   = end_len;
    comp_need     = 10'd6 + 10'd3 * {2'b00, comps_nxt};
    end_sof       = (marker_r == jhp_pkg::MK_SOF0);
    end_scan      = (marker_r == jhp_pkg::MK_SOS);
    end_fail      = 1'b0;
    if (end_sof) begin
      end_fail = (seg_len_end < 16'd6) || (comps_nxt < 8'd1) || (comps_nxt > 8'd4) ||
                 (seg_len_end < {6'd0, comp_need});
    end else if (marker_r == jhp_pkg::MK_DRI) begin
      end_fail = seg_len_end < 16'd2;
    end else if (end_scan) begin
      end_fail = next_pos > {2'b00, jhp_pkg::LIM24};
    end
  end

  // Next-state logic for one byte
  logic        ok;
  logic [25:0] len26;
  logic [25:0] slen;

  always_comb begin
    phase_nxt = phase_r; pos_nxt = pos_r; seg_rem_nxt = seg_rem_r; seg_pos_nxt = seg_pos_r;
    marker_nxt = marker_r; tleft_nxt = tleft_r; tcoll_nxt = tcoll_r; prec_nxt = prec_r;
    height_nxt = height_r; width_nxt = width_r; comps_nxt = comps_r; samp_nxt = samp_r;
    dri_nxt = dri_r; seen_sof_nxt = seen_sof_r; seen_sos_nxt = seen_sos_r; err_nxt = err_r;
    prev_nxt = prev_r; sstart_nxt = sstart_r;
    emit = 1'b0;
    ok = 1'b0; len26 = '0; slen = '0;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;

    if (accept) begin
      unique case (phase_r)
        jhp_pkg::PH_SOI_FF: begin
          if (b != jhp_pkg::BYTE_FF) begin
            err_nxt = 1'b1; phase_nxt = jhp_pkg::PH_FAIL;
          end else phase_nxt = jhp_pkg::PH_SOI_CODE;
        end
        jhp_pkg::PH_SOI_CODE: begin
          if (b != jhp_pkg::MK_SOI) begin
            err_nxt = 1'b1; phase_nxt = jhp_pkg::PH_FAIL;
          end else phase_nxt = jhp_pkg::PH_MARK_FF;
        end
        jhp_pkg::PH_MARK_FF: begin
          if (!last) begin
            if (b != jhp_pkg::BYTE_FF) begin
              err_nxt = 1'b1; phase_nxt = jhp_pkg::PH_FAIL;
            end else phase_nxt = jhp_pkg::PH_MARK;
          end
        end
        jhp_pkg::PH_MARK: begin
          if (b == jhp_pkg::BYTE_FF) begin
            if (last) begin
              err_nxt = 1'b1; phase_nxt = jhp_pkg::PH_FAIL;
            end
          end else begin
            marker_nxt = b;
            if (standalone) phase_nxt = jhp_pkg::PH_MARK_FF;
            else if (last) begin
              err_nxt = 1'b1; phase_nxt = jhp_pkg::PH_FAIL;
            end else phase_nxt = jhp_pkg::PH_LEN_HI;
          end
        end
        jhp_pkg::PH_LEN_HI: begin
          if (last) begin
            err_nxt = 1'b1; phase_nxt = jhp_pkg::PH_FAIL;
          end else begin
            seg_rem_nxt = {b, 8'h00};
            phase_nxt   = jhp_pkg::PH_LEN_LO;
          end
        end
        jhp_pkg::PH_LEN_LO: begin
          if (seg_full < 16'd2) begin
            err_nxt = 1'b1; phase_nxt = jhp_pkg::PH_FAIL;
          end else begin
            seg_rem_nxt = seg_after_len;
            seg_pos_nxt = '0;
            tleft_nxt   = '0;
            if (seg_after_len == 16'd0) begin
              phase_nxt = jhp_pkg::PH_MARK_FF;
              if (end_fail) begin
                err_nxt = 1'b1; phase_nxt = jhp_pkg::PH_FAIL;
                if (end_scan) begin
                  seen_sos_nxt = 1'b1; sstart_nxt = jhp_pkg::LIM24;
                end
              end else if (end_sof) begin
                if (comps_nxt < 8'd3) samp_nxt = 1'b0;
                seen_sof_nxt = 1'b1;
              end else if (end_scan) begin
                seen_sos_nxt = 1'b1; sstart_nxt = next_pos[23:0];
                phase_nxt = jhp_pkg::PH_SCAN;
              end
            end else if (last) begin
              err_nxt = 1'b1; phase_nxt = jhp_pkg::PH_FAIL;
            end else phase_nxt = jhp_pkg::PH_DATA;
          end
        end
        jhp_pkg::PH_DATA: begin
          seg_rem_nxt = seg_dec;
          seg_pos_nxt = seg_pos_r + 16'd1;
          if (marker_r == jhp_pkg::MK_DQT) begin
            if (tleft_r == 8'd0) begin
              if ((seg_dec < {8'd0, tsize}) ||
                  (tsum > (TW+1)'(MAX_TABLE_BYTES))) begin
                err_nxt = 1'b1; phase_nxt = jhp_pkg::PH_FAIL;
              end else begin
                tleft_nxt = tsize;
                if ((b[7:4] != 4'd0) && !b[3]) prec_nxt = prec_r | (8'd1 << b[2:0]);
              end
            end else begin
              tleft_nxt = tleft_r - 8'd1;
              emit      = 1'b1;
              tcoll_nxt = tcoll_r + TW'(1);
            end
          end else if (marker_r == jhp_pkg::MK_SOF0) begin
            case (seg_pos_r)
              16'd1: height_nxt[15:8] = b;
              16'd2: height_nxt[7:0]  = b;
              16'd3: width_nxt[15:8]  = b;
              16'd4: width_nxt[7:0]   = b;
              16'd5: comps_nxt        = b;
              16'd7: samp_nxt         = (b == 8'h22);
              default: ;
            endcase
          end else if (marker_r == jhp_pkg::MK_DRI) begin
            case (seg_pos_r)
              16'd0: dri_nxt[15:8] = b;
              16'd1: dri_nxt[7:0]  = b;
              default: ;
            endcase
          end
          if (!err_nxt) begin
            if (seg_dec == 16'd0) begin
              phase_nxt = jhp_pkg::PH_MARK_FF;
              if (end_fail) begin
                err_nxt = 1'b1; phase_nxt = jhp_pkg::PH_FAIL;
                if (end_scan) begin
                  seen_sos_nxt = 1'b1; sstart_nxt = jhp_pkg::LIM24;
                end
              end else if (end_sof) begin
                if (comps_nxt < 8'd3) samp_nxt = 1'b0;
                seen_sof_nxt = 1'b1;
              end else if (end_scan) begin
                seen_sos_nxt = 1'b1; sstart_nxt = next_pos[23:0];
                phase_nxt = jhp_pkg::PH_SCAN;
              end
            end else if (last) begin
              err_nxt = 1'b1; phase_nxt = jhp_pkg::PH_FAIL;
            end
          end
        end
        default: ;
      endcase

      if (last) begin
        // End-of-frame summary from the state after this byte, then clear
        len26 = next_pos;
        ok = !err_nxt && (len26 >= 26'd4) && seen_sof_nxt && seen_sos_nxt &&
             (tcoll_nxt != '0);
        if (seen_sos_nxt) begin
          if ({2'b00, sstart_nxt} + 26'd2 <= len26) begin
            slen = len26 - 26'd2 - {2'b00, sstart_nxt};
          end else ok = 1'b0;
          if (!(prev_r == jhp_pkg::BYTE_FF && b == jhp_pkg::MK_EOI)) ok = 1'b0;
        end
        if (slen > {2'b00, jhp_pkg::LIM24}) begin
          slen = {2'b00, jhp_pkg::LIM24}; ok = 1'b0;
        end
        out_valid_nxt = 1'b1;
        out_data_nxt.result_kind      = jhp_pkg::RK_SUMMARY;
        out_data_nxt.table_byte       = '0;
        out_data_nxt.table_index      = '0;
        out_data_nxt.frame_ok         = ok;
        out_data_nxt.frame_type       = {(dri_nxt != 16'd0), 5'd0, samp_nxt};
        out_data_nxt.width_units      = (width_nxt > jhp_pkg::DIM_MAX) ? 8'd0 : width_nxt[10:3];
        out_data_nxt.height_units     = (height_nxt > jhp_pkg::DIM_MAX) ? 8'd0 : height_nxt[10:3];
        out_data_nxt.dri_interval     = dri_nxt;
        out_data_nxt.table_length     = 10'(tcoll_nxt);
        out_data_nxt.table_precision  = prec_nxt;
        out_data_nxt.scan_begin       = seen_sos_nxt ? sstart_nxt : 24'd0;
        out_data_nxt.scan_length      = slen[23:0];
        phase_nxt = jhp_pkg::PH_SOI_FF; pos_nxt = '0; seg_rem_nxt = '0; seg_pos_nxt = '0;
        marker_nxt = '0; tleft_nxt = '0; tcoll_nxt = '0; prec_nxt = '0; height_nxt = '0;
        width_nxt = '0; comps_nxt = '0; samp_nxt = 1'b0; dri_nxt = '0; seen_sof_nxt = 1'b0;
        seen_sos_nxt = 1'b0; err_nxt = 1'b0; prev_nxt = '0; sstart_nxt = '0;
      end else begin
        prev_nxt = b;
        if (pos_r < jhp_pkg::POS_MAX) pos_nxt = next_pos[24:0];
        if (emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.result_kind = jhp_pkg::RK_TABLE;
          out_data_nxt.table_byte  = b;
          out_data_nxt.table_index = 9'(tcoll_r);
        end
      end
    end
  end

  // State and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jhp_pkg::PH_SOI_FF; pos_r <= '0; seg_rem_r <= '0; seg_pos_r <= '0;
      marker_r <= '0; tleft_r <= '0; tcoll_r <= '0; prec_r <= '0; height_r <= '0;
      width_r <= '0; comps_r <= '0; samp_r <= 1'b0; dri_r <= '0; seen_sof_r <= 1'b0;
      seen_sos_r <= 1'b0; err_r <= 1'b0; prev_r <= '0; sstart_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; pos_r <= pos_nxt; seg_rem_r <= seg_rem_nxt;
      seg_pos_r <= seg_pos_nxt; marker_r <= marker_nxt; tleft_r <= tleft_nxt;
      tcoll_r <= tcoll_nxt; prec_r <= prec_nxt; height_r <= height_nxt;
      width_r <= width_nxt; comps_r <= comps_nxt; samp_r <= samp_nxt; dri_r <= dri_nxt;
      seen_sof_r <= seen_sof_nxt; seen_sos_r <= seen_sos_nxt; err_r <= err_nxt;
      prev_r <= prev_nxt; sstart_r <= sstart_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Checks
  a_fail_has_error: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == jhp_pkg::PH_FAIL) |-> err_r)
    else $error("fail phase without error flag");

  a_table_limit: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, tcoll_r} <= (TW+1)'(MAX_TABLE_BYTES))
    else $error("table bytes exceed limit");

  a_summary_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last) |=> (phase_r == jhp_pkg::PH_SOI_FF && pos_r == '0 && !err_r))
    else $error("state not cleared after summary");

  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("held result changed");

endmodule

`default_nettype wire

// File: sim/jpeg_header_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// jpeg_header_parser_unit_tb
// Drives byte streams of JPEG frames, well formed and damaged, through the
// parser and checks every table byte and end-of-frame summary against a
// behavioural predictor of the marker parser, under random valid/stall gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_header_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TBL = 512;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  jhp_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  jhp_pkg::out_item_t out_data;

  jpeg_header_parser_unit #(.MAX_TABLE_BYTES(MAX_TBL)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // stimulus and expectation stores
  jhp_pkg::in_item_t  byte_q[$];
  jhp_pkg::out_item_t expected_q[$];
  int        n_errors = 0;
  int        n_results = 0;
  int        n_summaries = 0;
  int        n_good = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_cycles = 0;
  bit        pause_sender = 1'b0;

  // ---- predictor state ----
  jhp_pkg::phase_t ph;
  logic [24:0] fpos;
  logic [15:0] seg_rem, seg_pos;
  logic [7:0]  cur_mk, tbl_left, prec, ncomp;
  logic [9:0]  tbl_count;
  logic [15:0] hgt, wid, dri;
  logic        samp, got_sof, got_sos, err;
  logic [15:0] recent;
  logic [23:0] scan_at;

  function automatic void parser_clear();
    ph = jhp_pkg::PH_SOI_FF; fpos = '0; seg_rem = '0; seg_pos = '0; cur_mk = '0;
    tbl_left = '0; tbl_count = '0; prec = '0; hgt = '0; wid = '0; ncomp = '0;
    samp = 1'b0; dri = '0; got_sof = 1'b0; got_sos = 1'b0; err = 1'b0;
    recent = '0; scan_at = '0;
  endfunction

  function automatic void parser_fail();
    err = 1'b1;
    ph = jhp_pkg::PH_FAIL;
  endfunction

  // segment close-out; nxt is the frame offset just after the segment
  function automatic void segment_done(logic [25:0] nxt);
    int unsigned len;
    len = {16'd0, seg_pos};
    ph = jhp_pkg::PH_MARK_FF;
    if (cur_mk == jhp_pkg::MK_SOF0) begin
      if (len < 6 || ncomp < 1 || ncomp > 4 || len < 6 + 3 * ncomp) begin
        parser_fail();
        return;
      end
      if (ncomp < 3) samp = 1'b0;
      got_sof = 1'b1;
    end else if (cur_mk == jhp_pkg::MK_DRI) begin
      if (len < 2) parser_fail();
    end else if (cur_mk == jhp_pkg::MK_SOS) begin
      got_sos = 1'b1;
      if (nxt > {2'b00, jhp_pkg::LIM24}) begin
        scan_at = jhp_pkg::LIM24;
        parser_fail();
        return;
      end
      scan_at = nxt[23:0];
      ph = jhp_pkg::PH_SCAN;
    end
  endfunction

  // segment payload byte; returns 1 when it is a table byte to copy out
  function automatic bit segment_byte(logic [7:0] b);
    int unsigned sz;
    if (cur_mk == jhp_pkg::MK_DQT) begin
      if (tbl_left == 0) begin
        sz = (b[7:4] == 0) ? 64 : 128;
        if (seg_rem < sz || tbl_count + sz > MAX_TBL) begin
          parser_fail();
          return 1'b0;
        end
        tbl_left = 8'(sz);
        if (b[7:4] != 0 && b[3:0] < 8) prec[b[2:0]] = 1'b1;
        return 1'b0;
      end
      tbl_left--;
      return 1'b1;
    end
    if (cur_mk == jhp_pkg::MK_SOF0) begin
      case (seg_pos)
        1: hgt[15:8] = b;
        2: hgt[7:0] = b;
        3: wid[15:8] = b;
        4: wid[7:0] = b;
        5: ncomp = b;
        7: samp = (b == 8'h22);
        default: ;
      endcase
    end else if (cur_mk == jhp_pkg::MK_DRI) begin
      if (seg_pos == 0) dri[15:8] = b;
      else if (seg_pos == 1) dri[7:0] = b;
    end
    return 1'b0;
  endfunction

  // one accepted byte: update the parser copy and queue any result
  function automatic void predict_byte(jhp_pkg::in_item_t it);
    logic [7:0]  b;
    logic        lst, emit, ok;
    logic [24:0] p;
    logic [8:0]  idx;
    logic [15:0] seg;
    int unsigned flen, slen;
    jhp_pkg::out_item_t r;
    b = it.data_byte; lst = it.last_byte; p = fpos; emit = 1'b0; idx = '0;
    case (ph)
      jhp_pkg::PH_SOI_FF: begin
        if (b != jhp_pkg::BYTE_FF) parser_fail(); else ph = jhp_pkg::PH_SOI_CODE;
      end
      jhp_pkg::PH_SOI_CODE: begin
        if (b != jhp_pkg::MK_SOI) parser_fail(); else ph = jhp_pkg::PH_MARK_FF;
      end
      jhp_pkg::PH_MARK_FF: begin
        if (!lst) begin
          if (b != jhp_pkg::BYTE_FF) parser_fail(); else ph = jhp_pkg::PH_MARK;
        end
      end
      jhp_pkg::PH_MARK: begin
        if (b == jhp_pkg::BYTE_FF) begin
          if (lst) parser_fail();
        end else begin
          cur_mk = b;
          if (b == jhp_pkg::MK_EOI || b == 8'h00 || b == 8'h01 || (b >= 8'hD0 && b <= 8'hD7))
            ph = jhp_pkg::PH_MARK_FF;
          else if (lst) parser_fail();
          else ph = jhp_pkg::PH_LEN_HI;
        end
      end
      jhp_pkg::PH_LEN_HI: begin
        if (lst) parser_fail();
        else begin
          seg_rem = {b, 8'h00};
          ph = jhp_pkg::PH_LEN_LO;
        end
      end
      jhp_pkg::PH_LEN_LO: begin
        seg = seg_rem | {8'h00, b};
        if (seg < 2) parser_fail();
        else begin
          seg_rem = seg - 16'd2;
          seg_pos = '0;
          tbl_left = '0;
          if (seg_rem == 0) segment_done({1'b0, p} + 26'd1);
          else if (lst) parser_fail();
          else ph = jhp_pkg::PH_DATA;
        end
      end
      jhp_pkg::PH_DATA: begin
        seg_rem--;
        if (segment_byte(b)) begin
          emit = 1'b1;
          idx = tbl_count[8:0];
          tbl_count++;
        end
        seg_pos++;
        if (!err) begin
          if (seg_rem == 0) segment_done({1'b0, p} + 26'd1);
          else if (lst) parser_fail();
        end
      end
      default: ;
    endcase

    r = '0;
    if (lst) begin
      flen = {7'd0, p} + 32'd1;
      slen = 0;
      ok = !err && flen >= 4 && got_sof && got_sos && tbl_count != 0;
      if (got_sos) begin
        if (scan_at + 2 <= flen) slen = flen - 2 - scan_at;
        else ok = 1'b0;
        if (!(recent[7:0] == jhp_pkg::BYTE_FF && b == jhp_pkg::MK_EOI)) ok = 1'b0;
      end
      if (slen > jhp_pkg::LIM24) begin
        slen = {8'd0, jhp_pkg::LIM24};
        ok = 1'b0;
      end
      r.result_kind = jhp_pkg::RK_SUMMARY;
      r.frame_ok = ok;
      r.frame_type = {dri != 0, 5'd0, samp};
      r.width_units = (wid > jhp_pkg::DIM_MAX) ? 8'd0 : wid[10:3];
      r.height_units = (hgt > jhp_pkg::DIM_MAX) ? 8'd0 : hgt[10:3];
      r.dri_interval = dri;
      r.table_length = tbl_count;
      r.table_precision = prec;
      r.scan_begin = got_sos ? scan_at : 24'd0;
      r.scan_length = slen[23:0];
      expected_q.push_back(r);
      parser_clear();
      return;
    end
    recent = {recent[7:0], b};
    if (fpos < jhp_pkg::POS_MAX) fpos++;
    if (emit) begin
      r.result_kind = jhp_pkg::RK_TABLE;
      r.table_byte = b;
      r.table_index = idx;
      expected_q.push_back(r);
    end
  endfunction

  // ---- frame builders ----
  function automatic void put(logic [7:0] b, bit lst = 1'b0);
    jhp_pkg::in_item_t it;
    it.data_byte = b;
    it.last_byte = lst;
    byte_q.push_back(it);
  endfunction

  function automatic void put_seg(logic [7:0] mk, int len);
    put(jhp_pkg::BYTE_FF); put(mk); put(len[15:8]); put(len[7:0]);
  endfunction

  // a frame; mode 0 clean, 1 with random corruption, 2 pure noise
  function automatic void build_frame(int mode, bit big_tables);
    int ntab, sz, ncmp, scan_n, k, j;
    logic [15:0] w, h;
    if (mode == 2) begin
      k = $urandom_range(1, 12);
      for (j = 0; j < k; j++) put(8'($urandom), j == k - 1);
      return;
    end
    put(jhp_pkg::BYTE_FF); put(jhp_pkg::MK_SOI);
    if ($urandom_range(0, 3) == 0) put(jhp_pkg::BYTE_FF); // fill byte
    ntab = big_tables ? $urandom_range(1, 4) : $urandom_range(0, 2);
    for (k = 0; k < ntab; k++) begin
      sz = (big_tables || $urandom_range(0, 1)) ? 128 : 64;
      put_seg(jhp_pkg::MK_DQT, sz + 3);
      put({sz == 128 ? 4'($urandom_range(1, 15)) : 4'h0, 4'($urandom)});
      for (j = 0; j < sz; j++) put(8'($urandom));
    end
    if ($urandom_range(0, 1)) begin
      put_seg(jhp_pkg::MK_DRI, 4);
      put($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom));
      put(8'($urandom));
    end
    if ($urandom_range(0, 7) != 0) begin
      ncmp = $urandom_range(1, 4);
      w = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2048));
      h = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2048));
      put_seg(jhp_pkg::MK_SOF0, 8 + 3 * ncmp);
      put(8'd8); put(h[15:8]); put(h[7:0]); put(w[15:8]); put(w[7:0]); put(8'(ncmp));
      for (j = 0; j < ncmp; j++) begin
        put(8'(j + 1));
        put(j == 0 ? ($urandom_range(0, 1) ? 8'h22 : 8'h21) : 8'h11);
        put(j == 0 ? 8'h00 : 8'h01);
      end
    end
    if ($urandom_range(0, 5) == 0) put(8'hD3 - 8'h10 * 8'($urandom_range(0, 0)));
    if ($urandom_range(0, 7) != 0) begin
      put_seg(jhp_pkg::MK_SOS, 8);
      for (j = 0; j < 6; j++) put(8'($urandom));
      scan_n = $urandom_range(0, 20);
      for (j = 0; j < scan_n; j++) put(8'($urandom));
    end
    if (mode == 1) begin
      // corrupt one random byte of the frame built so far
      k = $urandom_range(0, 40);
      if (k < byte_q.size()) byte_q[byte_q.size() - 1 - k].data_byte = 8'($urandom);
    end
    if ($urandom_range(0, 9) == 0) put(8'($urandom), 1'b1);
    else begin
      put(jhp_pkg::BYTE_FF); put(jhp_pkg::MK_EOI, 1'b1);
    end
  endfunction

  // ---- driver: feeds byte_q under random sender gaps ----
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (in_valid) predict_byte(in_data);
        if (byte_q.size() > 0 && !pause_sender &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= byte_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- monitor: receiver stall and result check ----
  always @(posedge clk) begin
    jhp_pkg::out_item_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_q.size() == 0) begin
          $error("unexpected result kind=%0d", out_data.result_kind);
          n_errors++;
        end else begin
          e = expected_q.pop_front();
          if (e.result_kind == jhp_pkg::RK_SUMMARY) begin
            n_summaries++;
            if (e.frame_ok) n_good++;
          end
          if (out_data.result_kind !== e.result_kind) begin
            $error("result_kind exp %0d got %0d", e.result_kind, out_data.result_kind);
            n_errors++;
          end
          if (out_data.table_byte !== e.table_byte) begin
            $error("table_byte exp %0h got %0h", e.table_byte, out_data.table_byte);
            n_errors++;
          end
          if (out_data.table_index !== e.table_index) begin
            $error("table_index exp %0d got %0d", e.table_index, out_data.table_index);
            n_errors++;
          end
          if (out_data.frame_ok !== e.frame_ok) begin
            $error("frame_ok exp %0d got %0d", e.frame_ok, out_data.frame_ok);
            n_errors++;
          end
          if (out_data.frame_type !== e.frame_type) begin
            $error("frame_type exp %0d got %0d", e.frame_type, out_data.frame_type);
            n_errors++;
          end
          if (out_data.width_units !== e.width_units) begin
            $error("width_units exp %0d got %0d", e.width_units, out_data.width_units);
            n_errors++;
          end
          if (out_data.height_units !== e.height_units) begin
            $error("height_units exp %0d got %0d", e.height_units, out_data.height_units);
            n_errors++;
          end
          if (out_data.dri_interval !== e.dri_interval) begin
            $error("dri_interval exp %0d got %0d", e.dri_interval,
                   out_data.dri_interval);
            n_errors++;
          end
          if (out_data.table_length !== e.table_length) begin
            $error("table_length exp %0d got %0d", e.table_length, out_data.table_length);
            n_errors++;
          end
          if (out_data.table_precision !== e.table_precision) begin
            $error("table_precision exp %0h got %0h", e.table_precision,
                   out_data.table_precision);
            n_errors++;
          end
          if (out_data.scan_begin !== e.scan_begin) begin
            $error("scan_begin exp %0d got %0d", e.scan_begin, out_data.scan_begin);
            n_errors++;
          end
          if (out_data.scan_length !== e.scan_length) begin
            $error("scan_length exp %0d got %0d", e.scan_length, out_data.scan_length);
            n_errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // wait until the driver has sent every queued byte and the results are in
  task automatic drain();
    while (byte_q.size() > 0 || in_valid) @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---- test sequence ----
  initial begin
    int f;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: short / bad starts, standalone markers, bad length, filler
    put(8'h00, 1'b1);
    put(jhp_pkg::BYTE_FF); put(jhp_pkg::MK_SOI); put(jhp_pkg::BYTE_FF);
    put(jhp_pkg::MK_EOI, 1'b1);
    put(jhp_pkg::BYTE_FF); put(jhp_pkg::MK_SOI); put(jhp_pkg::BYTE_FF); put(8'hD0);
    put(jhp_pkg::BYTE_FF); put(8'h01);
    put(jhp_pkg::BYTE_FF); put(8'h00); put(jhp_pkg::BYTE_FF); put(jhp_pkg::BYTE_FF);
    put(8'hD7);
    put(jhp_pkg::BYTE_FF); put(8'hC4); put(8'h00); put(8'h01); put(8'hFF, 1'b1);
    put(jhp_pkg::BYTE_FF); put(jhp_pkg::MK_SOI); put(jhp_pkg::BYTE_FF);
    put(jhp_pkg::MK_DQT); put(8'h00); put(8'h43);
    put(8'h00); put(8'h7F, 1'b1);
    put(jhp_pkg::BYTE_FF); put(jhp_pkg::MK_SOI); put(jhp_pkg::BYTE_FF, 1'b1);
    for (f = 0; f < 2; f++) build_frame(0, 1'b0);
    build_frame(0, 1'b1);

    // random phase one: sender idles often, receiver more
    send_idle_pct = 29; recv_idle_pct = 56;
    for (f = 0; f < 3; f++) build_frame($urandom_range(0, 9) < 7 ? 0 : ($urandom_range(1, 2)),
                                        1'b0);
    drain();

    // sender stops mid-frame until every expected result has arrived
    build_frame(0, 1'b0);
    repeat (40) @(posedge clk);
    pause_sender = 1'b1;
    while (expected_q.size() > 0 || in_valid) @(posedge clk);
    repeat (20) @(posedge clk);
    pause_sender = 1'b0;
    drain();

    // long receiver hold-off while bytes keep coming
    send_idle_pct = 0; recv_idle_pct = 0;
    build_frame(0, 1'b0);
    @(posedge clk);
    hold_cycles = 300;
    drain();

    send_idle_pct = 56; recv_idle_pct = 29;
    for (f = 0; f < 3; f++) build_frame($urandom_range(0, 9) < 7 ? 0 : 1, 1'b0);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    for (f = 0; f < 2; f++) build_frame($urandom_range(0, 9) < 8 ? 0 : 2, 1'b0);
    drain();
    repeat (10) @(posedge clk);

    $display("Checked %0d results, %0d frame summaries (%0d passing frames).",
             n_results, n_summaries, n_good);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
